[hw/rtl/ucps_pkg.sv]
// Shared types and constants of the UTF-8 complete-prefix scanner.
// No dependencies; ucps_eval and the top level import it.
package ucps_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int OUT_W           = 16;

    localparam logic [7:0] ASCII_HI  = 8'h7f;
    localparam logic [7:0] LEAD2_LO  = 8'hc2;
    localparam logic [7:0] LEAD2_HI  = 8'hdf;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD3_HI  = 8'hef;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] LEAD4_HI  = 8'hf4;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam logic [20:0] CP_MAX    = 21'h10ffff;
    localparam logic [20:0] SURR_LO   = 21'h00d800;
    localparam logic [20:0] SURR_HI   = 21'h00dfff;
    localparam logic [20:0] MIN_3BYTE = 21'h000800;
    localparam logic [20:0] MIN_4BYTE = 21'h010000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // One evaluation pass over the head of the window.
    typedef struct packed {
        logic       stop;  // head sequence not fully present yet
        logic [2:0] drop;  // bytes to settle and shift out (1..4)
    } t_eval;

endpackage

[hw/rtl/ucps_in_if.sv]
// Input channel of the scanner: one raw byte and its end-of-buffer flag.
// Depends on nothing.
interface ucps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[hw/rtl/ucps_out_if.sv]
// Result channel of the scanner: length of the complete leading part.
// Depends on nothing.
interface ucps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] complete_length;

    modport source (output valid, output complete_length, input ready);
    modport sink   (input valid, input complete_length, output ready);
endinterface

[hw/rtl/ucps_eval.sv]
// Shared sequence evaluator: decodes the lead byte of the window and
// judges the sequence when complete. Depends on ucps_pkg.
module ucps_eval
    import ucps_pkg::*;
(
    input  logic [7:0] i_win [4],
    input  logic [2:0] i_len,
    output t_eval      o_eval
);

    logic [2:0]  need;
    logic [20:0] cp;
    logic        cont_ok;
    logic        valid;

    always_comb begin
        need    = 3'd0;
        cp      = 21'd0;
        cont_ok = 1'b1;
        if (i_win[0] <= ASCII_HI) begin
            need = 3'd1;
            cp   = {13'd0, i_win[0]};
        end else if (i_win[0] inside {[LEAD2_LO:LEAD2_HI]}) begin
            need    = 3'd2;
            cp      = {10'd0, i_win[0][4:0], i_win[1][5:0]};
            cont_ok = ((i_win[1] & CONT_MASK) == CONT_TAG);
        end else if (i_win[0] inside {[LEAD3_LO:LEAD3_HI]}) begin
            need    = 3'd3;
            cp      = {5'd0, i_win[0][3:0], i_win[1][5:0], i_win[2][5:0]};
            cont_ok = ((i_win[1] & CONT_MASK) == CONT_TAG)
                   && ((i_win[2] & CONT_MASK) == CONT_TAG);
        end else if (i_win[0] inside {[LEAD4_LO:LEAD4_HI]}) begin
            need    = 3'd4;
            cp      = {i_win[0][2:0], i_win[1][5:0], i_win[2][5:0], i_win[3][5:0]};
            cont_ok = ((i_win[1] & CONT_MASK) == CONT_TAG)
                   && ((i_win[2] & CONT_MASK) == CONT_TAG)
                   && ((i_win[3] & CONT_MASK) == CONT_TAG);
        end

        valid = cont_ok && (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI))
             && !((need == 3'd3) && (cp < MIN_3BYTE))
             && !((need == 3'd4) && (cp < MIN_4BYTE));

        o_eval.stop = (need != 3'd0) && (need > i_len);
        o_eval.drop = ((need == 3'd0) || !valid) ? 3'd1 : need;
    end

endmodule

[hw/rtl/utf8_complete_prefix_scanner.sv]
// Top level of the UTF-8 complete-prefix scanner: window, sequencer,
// saturating count and result register. Depends on ucps_pkg, ucps_in_if,
// ucps_out_if and ucps_eval.
//
//  channel  | dir | payload                          | transfer when
//  ---------+-----+----------------------------------+------------------
//  i_in     | in  | data_byte[7:0], end_of_buffer    | valid && ready
//  o_out    | out | complete_length[15:0]            | valid && ready
//
// A byte is taken in the idle state; then the scan state settles the head
// sequences of the window in turn and ends when the head still waits for
// followers or the window empties; the single shared evaluator judges one
// head sequence at a time. The final byte of a buffer then passes the load
// state, which loads the result register. i_in.ready is high only while
// the sequencer idles. A result that is not taken stalls the next final
// byte in the load state; other bytes keep flowing. Synchronous reset
// empties the window and clears the count and the result valid flag.
module utf8_complete_prefix_scanner
    import ucps_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ucps_in_if.sink    i_in,
    ucps_out_if.source o_out
);

    localparam logic [LENGTH_BITS:0] CountMax = {1'b0, {LENGTH_BITS{1'b1}}};

    t_state                 r_state, n_state;
    logic [7:0]             r_win [4];
    logic [2:0]             r_len;
    logic                   r_eob;
    logic [LENGTH_BITS-1:0] r_count;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_len;

    t_eval                  ev;
    logic                   accept;
    logic                   out_free;
    logic                   scan_done;
    logic [2:0]             rest_len;
    logic [LENGTH_BITS:0]   sum;
    logic [LENGTH_BITS-1:0] count_sat;

    ucps_eval u_eval (
        .i_win  (r_win),
        .i_len  (r_len),
        .o_eval (ev)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign rest_len = r_len - ev.drop;
    // finish the byte when the head waits for followers or the window empties
    assign scan_done = ev.stop || (rest_len == 3'd0);

    assign sum       = {1'b0, r_count} + (LENGTH_BITS+1)'(ev.drop);
    assign count_sat = (sum > CountMax) ? r_count | {LENGTH_BITS{1'b1}}
                                        : sum[LENGTH_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = r_eob ? ST_DONE : ST_IDLE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            default: i_in.ready = 1'b0;
        endcase
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.complete_length = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= 3'd0;
            r_eob       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the load state handles a taken result itself
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    // append the new byte behind the held ones
                    if (accept) begin
                        r_win[r_len[1:0]] <= i_in.data_byte;
                        r_len             <= r_len + 3'd1;
                        r_eob             <= i_in.end_of_buffer;
                    end
                end
                ST_SCAN: begin
                    // settle the head sequence and shift it out
                    if (!ev.stop) begin
                        r_count <= count_sat;
                        r_len   <= rest_len;
                        for (int i = 0; i < 4; i++) begin
                            if (i + int'(ev.drop) < 4) r_win[i] <= r_win[i + int'(ev.drop)];
                        end
                    end
                end
                ST_DONE: begin
                    // drop the unfinished tail and publish the count
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_len   <= OUT_W'(r_count);
                        r_count     <= '0;
                        r_len       <= 3'd0;
                        r_eob       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN))
        else $error("accepted byte not scanned");

    a_idle_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_len <= 3'd3))
        else $error("window overfull while idle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the load state");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_count >= $past(r_count)))
        else $error("count decreased during scan");

endmodule
